// ===== rtl/tewc_pkg.sv =====
// Shared types and constants for the task event wake controller.
`timescale 1ns / 1ps
`default_nettype none

package tewc_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned TaskW   = 3;
  localparam int unsigned EventW  = 8;
  localparam int unsigned TmoW    = 16;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [OpW-1:0] {
    OP_ENABLE  = 3'd0,
    OP_DISABLE = 3'd1,
    OP_WAIT    = 3'd2,
    OP_SIGNAL  = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  // command given to every task slot; hit is set only for the addressed slot
  typedef struct packed {
    op_e               op;
    logic              hit;
    logic [EventW-1:0] ev;
    logic [TmoW-1:0]   tmo;
  } slot_cmd_t;

  // per-slot view of the state after the current command
  typedef struct packed {
    logic              en;
    logic              woken;
    logic [EventW-1:0] wake_event;
  } slot_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tewc_slot.sv =====
// Per-task state: enable bit, wait mask, wake event and timeout counter.
`timescale 1ns / 1ps
`default_nettype none

module tewc_slot #(
  parameter bit EnReset = 1'b0
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 commit_i,
  input  tewc_pkg::slot_cmd_t cmd_i,
  output tewc_pkg::slot_stat_t stat_o
);

  logic                        en_q, en_d;
  logic [tewc_pkg::EventW-1:0] mask_q, mask_d;
  logic [tewc_pkg::EventW-1:0] event_q, event_d;
  logic [tewc_pkg::TmoW-1:0]   tmo_q, tmo_d;
  logic                        woken;

  always_comb begin
    en_d    = en_q;
    mask_d  = mask_q;
    event_d = event_q;
    tmo_d   = tmo_q;
    woken   = 1'b0;
    case (cmd_i.op)
      tewc_pkg::OP_TICK: begin
        if (mask_q[0] && !en_q) begin
          if (tmo_q == '0) begin
            en_d    = 1'b1;
            event_d = tewc_pkg::EventW'(1);
            woken   = 1'b1;
          end else begin
            tmo_d = tmo_q - tewc_pkg::TmoW'(1);
          end
        end
      end
      tewc_pkg::OP_ENABLE: begin
        if (cmd_i.hit) en_d = 1'b1;
      end
      tewc_pkg::OP_DISABLE: begin
        if (cmd_i.hit) en_d = 1'b0;
      end
      tewc_pkg::OP_WAIT: begin
        if (cmd_i.hit) begin
          mask_d = cmd_i.ev;
          tmo_d  = cmd_i.tmo;
          en_d   = 1'b0;
        end
      end
      tewc_pkg::OP_SIGNAL: begin
        if (cmd_i.hit && !en_q && ((mask_q & cmd_i.ev) != '0)) begin
          en_d    = 1'b1;
          event_d = cmd_i.ev;
          woken   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= EnReset;
      mask_q  <= '0;
      event_q <= '0;
      tmo_q   <= '0;
    end else if (commit_i) begin
      en_q    <= en_d;
      mask_q  <= mask_d;
      event_q <= event_d;
      tmo_q   <= tmo_d;
    end
  end

  assign stat_o.en         = en_d;
  assign stat_o.woken      = woken;
  assign stat_o.wake_event = event_d;

endmodule

`default_nettype wire

// ===== rtl/task_event_wake_controller.sv =====
// Top level: input register, per-task slots and result register.
// Path: an input beat is held in the input register, then its result goes to the result register.
// Throughput: one beat per cycle while results are taken; all tasks update in parallel.
// Stalls: s_axis_tready drops while a held input beat waits behind an untaken result.
// Reset: asynchronous, active low; task 0 enabled, all masks, events and
// timeouts cleared, both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module task_event_wake_controller #(
  parameter int unsigned TASK_COUNT = 8
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // operation[2:0], task_req[5:3], event_set[13:6], timeout[29:14]
  input  wire  [tewc_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // enable_mask[7:0], wake_event[15:8], woken_mask[23:16]
  output logic [tewc_pkg::OutDataW-1:0]     m_axis_tdata
);

  logic                        in_vld_q;
  logic [tewc_pkg::OpW-1:0]    op_q;
  logic [tewc_pkg::TaskW-1:0]  task_q;
  logic [tewc_pkg::EventW-1:0] ev_q;
  logic [tewc_pkg::TmoW-1:0]   tmo_q;

  logic                        out_vld_q, out_vld_d;
  logic [tewc_pkg::MaskW-1:0]  en_mask_q, en_mask_d;
  logic [tewc_pkg::EventW-1:0] wake_ev_q, wake_ev_d;
  logic [tewc_pkg::MaskW-1:0]  woken_q, woken_d;

  logic advance;
  logic task_ok;
  tewc_pkg::slot_stat_t stat [TASK_COUNT];

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign task_ok       = {1'b0, task_q} < (tewc_pkg::TaskW + 1)'(TASK_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q   <= s_axis_tdata[2:0];
      task_q <= s_axis_tdata[5:3];
      ev_q   <= s_axis_tdata[13:6];
      tmo_q  <= s_axis_tdata[29:14];
    end
  end

  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_slot
    tewc_pkg::slot_cmd_t cmd;
    always_comb begin
      cmd.op  = tewc_pkg::op_e'(op_q);
      cmd.hit = (task_q == tewc_pkg::TaskW'(i));
      cmd.ev  = ev_q;
      cmd.tmo = tmo_q;
    end
    tewc_slot #(
      .EnReset(i == 0)
    ) u_slot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .commit_i(advance),
      .cmd_i   (cmd),
      .stat_o  (stat[i])
    );
  end

  always_comb begin
    en_mask_d = '0;
    woken_d   = '0;
    wake_ev_d = '0;
    for (int i = 0; i < TASK_COUNT; i++) begin
      en_mask_d[i] = stat[i].en;
      woken_d[i]   = stat[i].woken;
      if (task_ok && task_q == tewc_pkg::TaskW'(i)) begin
        wake_ev_d = stat[i].wake_event;
      end
    end
  end

  assign out_vld_d = advance || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      en_mask_q <= en_mask_d;
      wake_ev_q <= wake_ev_d;
      woken_q   <= woken_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {woken_q, wake_ev_q, en_mask_q};

endmodule

`default_nettype wire

// ===== rtl/tewc_checker.sv =====
// Port-level checks for the task event wake controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tewc_checker #(
  parameter int unsigned TASK_COUNT = 8
) (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           m_axis_tvalid,
  input wire                           m_axis_tready,
  input wire [tewc_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic [tewc_pkg::MaskW-1:0] en_mask;
  logic [tewc_pkg::MaskW-1:0] woken;
  logic [tewc_pkg::MaskW-1:0] live;

  assign en_mask = m_axis_tdata[7:0];
  assign woken   = m_axis_tdata[23:16];
  assign live    = tewc_pkg::MaskW'((16'd1 << TASK_COUNT) - 16'd1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_woken_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((woken & ~en_mask) == '0))
    else $error("woken task not enabled");

  a_no_ghost_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (((en_mask | woken) & ~live) == '0))
    else $error("bit set for task beyond task count");

endmodule

bind task_event_wake_controller tewc_checker #(
  .TASK_COUNT(TASK_COUNT)
) u_tewc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
